@@ rtl/core/rsbs_pkg.sv @@
// Shared types, codes and helpers of the record sort and search block.
`timescale 1ns / 1ps

package rsbs_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MATCH = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WR_LOAD = 2'd0,
    WR_BEST = 2'd1,
    WR_IREC = 2'd2
  } wr_src_t;

  typedef enum logic {
    OUT_ZERO = 1'b0,
    OUT_PEND = 1'b1
  } out_src_t;

  // Packed so the tag lands in the lowest bits.
  typedef struct packed {
    logic [7:0]  avg;
    logic [31:0] id;
    logic [15:0] tag;
  } rec_t;

  typedef struct packed {
    logic     rd_en;
    logic     wr_en;
    wr_src_t  wr_src;
    logic     cap_best;
    logic     cap_irec;
    logic     cap_pend;
    logic     cap_key;
    logic     out_load;
    out_src_t out_src;
    status_t  out_status;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic lt_best;
    logic eq;
    logic gt;
    logic mode;
  } stat_t;

  function automatic logic [31:0] key_of(input rec_t r, input logic mode);
    logic [31:0] k;
    k = mode ? {24'd0, r.avg} : r.id;
    return k;
  endfunction

endpackage

@@ rtl/core/rsbs_dpath.sv @@
// Datapath: record memory, key compare and holding registers.
`timescale 1ns / 1ps

module rsbs_dpath #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  rsbs_pkg::rec_t        in_rec,
  input  logic [31:0]           in_key,
  input  rsbs_pkg::cmd_t        cmd,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  output rsbs_pkg::stat_t       stat,
  output rsbs_pkg::rec_t        out_rec,
  output rsbs_pkg::status_t     out_status,
  output logic                  out_last
);

  rsbs_pkg::rec_t mem [TABLE_DEPTH];
  rsbs_pkg::rec_t rdata, best_rec, irec, pend_rec, wdata;
  logic [31:0]    qkey, rkey, bkey;
  logic           mode;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_we) mode <= cfg_data;
  end

  always_comb begin
    case (cmd.wr_src)
      rsbs_pkg::WR_LOAD: wdata = in_rec;
      rsbs_pkg::WR_BEST: wdata = best_rec;
      rsbs_pkg::WR_IREC: wdata = irec;
      default:           wdata = in_rec;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wdata;
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_best) best_rec <= rdata;
    if (cmd.cap_irec) irec <= rdata;
    if (cmd.cap_pend) pend_rec <= rdata;
    if (cmd.cap_key) qkey <= mode ? {24'd0, in_key[7:0]} : in_key;
    if (cmd.out_load) begin
      out_rec    <= (cmd.out_src == rsbs_pkg::OUT_PEND) ? pend_rec : '0;
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
    end
  end

  assign rkey = rsbs_pkg::key_of(rdata, mode);
  assign bkey = rsbs_pkg::key_of(best_rec, mode);

  assign stat.lt_best = rkey < bkey;
  assign stat.eq      = rkey == qkey;
  assign stat.gt      = rkey > qkey;
  assign stat.mode    = mode;

endmodule

@@ rtl/core/rsbs_ctrl.sv @@
// Controller: sequences load, clear, sort, search and result emission.
`timescale 1ns / 1ps

module rsbs_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW = $clog2(TABLE_DEPTH),
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsbs_pkg::op_t    in_op,
  input  logic             out_ready,
  output logic             out_valid,
  input  rsbs_pkg::stat_t  stat,
  output rsbs_pkg::cmd_t   cmd,
  output logic [AW-1:0]    rd_addr,
  output logic [AW-1:0]    wr_addr
);

  typedef enum logic [4:0] {
    S_IDLE, S_RESP, S_I, S_IW, S_SCAN, S_SW1, S_SW2,
    S_SRCH, S_MW, S_LW, S_HW, S_DN, S_DW, S_DP, S_UP, S_UW, S_UPP, S_FIN
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     n, n_next, i, i_next, j, j_next, pj, pj_next, best, best_next;
  logic [CW-1:0]     lo, lo_next, hi, hi_next, mid, mid_next, hit, hit_next, w, w_next;
  logic              mid_gt, mid_gt_next, out_valid_next;
  rsbs_pkg::status_t resp, resp_next;
  logic              free;
  logic [CW:0]       sum;

  assign free = !out_valid || out_ready;
  assign sum  = {1'b0, lo} + {1'b0, hi};

  always_comb begin
    state_next  = state;
    n_next      = n;
    i_next      = i;
    j_next      = j;
    pj_next     = pj;
    best_next   = best;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    hit_next    = hit;
    w_next      = w;
    mid_gt_next = mid_gt;
    resp_next   = resp;
    cmd         = '0;
    rd_addr     = '0;
    wr_addr     = '0;
    in_ready    = 1'b0;
    out_valid_next = out_valid && !out_ready;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            rsbs_pkg::OP_LOAD: begin
              if (n < CW'(TABLE_DEPTH)) begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = rsbs_pkg::WR_LOAD;
                wr_addr    = n[AW-1:0];
                n_next     = n + 1'b1;
                resp_next  = rsbs_pkg::ST_OK;
              end else begin
                resp_next  = rsbs_pkg::ST_FULL;
              end
              state_next = S_RESP;
            end
            rsbs_pkg::OP_QUERY: begin
              cmd.cap_key = 1'b1;
              i_next      = '0;
              if (n == '0) begin
                resp_next  = rsbs_pkg::ST_MISS;
                state_next = S_RESP;
              end else begin
                state_next = S_I;
              end
            end
            rsbs_pkg::OP_CLEAR: begin
              n_next     = '0;
              resp_next  = rsbs_pkg::ST_OK;
              state_next = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = rsbs_pkg::OUT_ZERO;
          cmd.out_status = resp;
          cmd.out_last   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      // Selection sort: one outer pass per position except the last.
      S_I: begin
        if (i + 1'b1 >= n) begin
          lo_next    = '0;
          hi_next    = n - 1'b1;
          state_next = S_SRCH;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = i[AW-1:0];
          best_next  = i;
          j_next     = i + 1'b1;
          state_next = S_IW;
        end
      end
      S_IW: begin
        cmd.cap_best = 1'b1;
        cmd.cap_irec = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = j[AW-1:0];
        pj_next      = j;
        j_next       = j + 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (stat.lt_best) begin
          cmd.cap_best = 1'b1;
          best_next    = pj;
        end
        if (j < n) begin
          cmd.rd_en = 1'b1;
          rd_addr   = j[AW-1:0];
          pj_next   = j;
          j_next    = j + 1'b1;
        end else begin
          state_next = S_SW1;
        end
      end
      S_SW1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = rsbs_pkg::WR_BEST;
        wr_addr    = i[AW-1:0];
        state_next = S_SW2;
      end
      S_SW2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = rsbs_pkg::WR_IREC;
        wr_addr    = best[AW-1:0];
        i_next     = i + 1'b1;
        state_next = S_I;
      end
      // Bisection: test mid, then lo, then hi.
      S_SRCH: begin
        mid_next   = sum[CW:1];
        cmd.rd_en  = 1'b1;
        rd_addr    = sum[AW:1];
        state_next = S_MW;
      end
      S_MW: begin
        if (stat.eq) begin
          cmd.cap_pend = 1'b1;
          hit_next     = mid;
          w_next       = mid;
          state_next   = stat.mode ? S_DN : S_FIN;
        end else begin
          mid_gt_next = stat.gt;
          cmd.rd_en   = 1'b1;
          rd_addr     = lo[AW-1:0];
          state_next  = S_LW;
        end
      end
      S_LW: begin
        if (stat.eq) begin
          cmd.cap_pend = 1'b1;
          hit_next     = lo;
          w_next       = lo;
          state_next   = stat.mode ? S_DN : S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = hi[AW-1:0];
          state_next = S_HW;
        end
      end
      S_HW: begin
        if (stat.eq) begin
          cmd.cap_pend = 1'b1;
          hit_next     = hi;
          w_next       = hi;
          state_next   = stat.mode ? S_DN : S_FIN;
        end else if ((hi - lo) <= CW'(1)) begin
          resp_next  = rsbs_pkg::ST_MISS;
          state_next = S_RESP;
        end else begin
          if (mid_gt) hi_next = mid - 1'b1;
          else lo_next = mid + 1'b1;
          state_next = S_SRCH;
        end
      end
      // In avg mode, walk down from the hit, then up; one result is held back so the
      // final one can carry last.
      S_DN: begin
        if (w == '0) begin
          w_next     = hit + 1'b1;
          state_next = S_UP;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = w[AW-1:0] - 1'b1;
          w_next     = w - 1'b1;
          state_next = S_DW;
        end
      end
      S_DW: begin
        if (stat.eq) begin
          state_next = S_DP;
        end else begin
          w_next     = hit + 1'b1;
          state_next = S_UP;
        end
      end
      S_DP: begin
        if (free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = rsbs_pkg::OUT_PEND;
          cmd.out_status = rsbs_pkg::ST_MATCH;
          cmd.cap_pend   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_DN;
        end
      end
      S_UP: begin
        if (w >= n) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = w[AW-1:0];
          state_next = S_UW;
        end
      end
      S_UW: begin
        state_next = stat.eq ? S_UPP : S_FIN;
      end
      S_UPP: begin
        if (free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = rsbs_pkg::OUT_PEND;
          cmd.out_status = rsbs_pkg::ST_MATCH;
          cmd.cap_pend   = 1'b1;
          out_valid_next = 1'b1;
          w_next         = w + 1'b1;
          state_next     = S_UP;
        end
      end
      S_FIN: begin
        if (free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = rsbs_pkg::OUT_PEND;
          cmd.out_status = rsbs_pkg::ST_MATCH;
          cmd.out_last   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      n         <= n_next;
      out_valid <= out_valid_next;
    end
    i      <= i_next;
    j      <= j_next;
    pj     <= pj_next;
    best   <= best_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    hit    <= hit_next;
    w      <= w_next;
    mid_gt <= mid_gt_next;
    resp   <= resp_next;
  end

endmodule

@@ rtl/core/record_sort_and_binary_search.sv @@
// Top level of the record table with selection sort and bisection search.
`timescale 1ns / 1ps
// Load and clear items are answered through the response state; a query
// first sorts the N loaded records, scanning them through the single read
// port of the record memory, then bisects and, in avg mode, walks over
// equal records. One item is worked on at a time.
// Synchronous reset empties the table and selects id mode; the memory keeps
// its contents, which are never read before being written.

module record_sort_and_binary_search #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // record_tag, student_id, average_score, query_key
  input  logic [1:0]  s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // match_tag, match_id, match_average
  output logic [1:0]  m_tuser,  // status
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  rsbs_pkg::cmd_t    cmd;
  rsbs_pkg::stat_t   stat;
  rsbs_pkg::rec_t    in_rec, out_rec;
  rsbs_pkg::status_t out_status;
  logic [AW-1:0]     rd_addr, wr_addr;

  // Register writes are taken at any time; the user must send them only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  assign in_rec.tag = s_tdata[15:0];
  assign in_rec.id  = s_tdata[47:16];
  assign in_rec.avg = s_tdata[55:48];

  rsbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (rsbs_pkg::op_t'(s_tuser)),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .stat      (stat),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  rsbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .in_rec     (in_rec),
    .in_key     (s_tdata[87:56]),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .stat       (stat),
    .out_rec    (out_rec),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = out_rec;
  assign m_tuser = out_status;

  // Any real item takes the controller out of idle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != rsbs_pkg::OP_NOP) |=> !s_tready)
    else $error("input accepted twice in a row");

  // Only match results carry a record.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != rsbs_pkg::ST_MATCH) |-> (m_tdata == '0))
    else $error("non-match result with payload");

  // Load, clear and not-found results are always single and final.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == rsbs_pkg::ST_OK || m_tuser == rsbs_pkg::ST_FULL ||
                  m_tuser == rsbs_pkg::ST_MISS)) |-> m_tlast)
    else $error("single result without last");

endmodule
